### src/lbf_pkg.sv
// shared types and constants of the led breathing and level fader
// no dependencies
`default_nettype none
package lbf_pkg;

    localparam int CHANNELS_DEF    = 6;
    localparam int LEVEL_STEPS_DEF = 20;
    localparam int OUT_CH          = 6;

    localparam int MODES_W    = 12;
    localparam int DIV_W      = 4;
    localparam int THRESH_W   = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = 12;
    localparam int HOLD_W     = 9;
    localparam int LEVEL_W    = 5;
    localparam int DUTY_W     = 8;
    localparam int DIVIDEND_W = 13;
    localparam int DIVISOR_W  = 8;

    localparam logic [DUTY_W-1:0] FULL      = 8'd255;
    localparam logic [HOLD_W-1:0] HOLD_TIME = 9'd511;

    localparam logic [CFG_IDX_W-1:0] REG_MODES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DARKEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 2'd3;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_BREATH = 2'd1;
    localparam logic [1:0] MODE_IDLE   = 2'd2;
    localparam logic [1:0] MODE_PUSH   = 2'd3;

    localparam logic [1:0] PH_UP     = 2'd0;
    localparam logic [1:0] PH_HOLD_H = 2'd1;
    localparam logic [1:0] PH_DOWN   = 2'd2;
    localparam logic [1:0] PH_HOLD_L = 2'd3;

    typedef struct packed {
        logic        func;
        logic [15:0] idle_ms;
    } t_in;

    typedef struct packed {
        logic [7:0] duty_ch0;
        logic [7:0] duty_ch1;
        logic [7:0] duty_ch2;
        logic [7:0] duty_ch3;
        logic [7:0] duty_ch4;
        logic [7:0] duty_ch5;
        logic [5:0] pwm_enable_mask;
    } t_out;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

endpackage
`default_nettype wire

### src/lbf_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on lbf_pkg
`default_nettype none
module lbf_divider (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lbf_pkg::t_div_req                  i_req,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [lbf_pkg::DIVIDEND_W-1:0]     o_quot
);
    import lbf_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_q, n_q;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy, r_done;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  ge;

    always_comb begin
        rem_sh = {r_rem, r_q[DIVIDEND_W-1]};
        ge     = rem_sh >= {1'b0, r_div};
        n_rem  = ge ? DIVISOR_W'(rem_sh - {1'b0, r_div}) : rem_sh[DIVISOR_W-1:0];
        n_q    = {r_q[DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

### src/led_breathing_and_level_fader.sv
// led breathing and pushed-level fader, channels handled one after another
// per channel: S_LOAD, then S_DIV when a division is needed, then S_WRITE;
// after the last channel S_OUT presents the result; one item in flight at a time
// the 13-step shared divider sets the pace; synchronous active-low reset
// clears all channel state and loads the register defaults
// depends on lbf_pkg and lbf_divider
`default_nettype none
module led_breathing_and_level_fader #(
    parameter int CHANNELS    = lbf_pkg::CHANNELS_DEF,
    parameter int LEVEL_STEPS = lbf_pkg::LEVEL_STEPS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  lbf_pkg::t_in                      i_data,
    output logic                              o_valid,
    input  wire                               i_stall,
    output lbf_pkg::t_out                     o_data,
    input  wire                               i_cfg_we,
    input  wire [lbf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [lbf_pkg::CFG_W-1:0]          i_cfg_data
);
    import lbf_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [LEVEL_W-1:0]   LSTEPS   = LEVEL_W'(LEVEL_STEPS);
    localparam logic [DIVISOR_W-1:0] LOSS_DIV = DIVISOR_W'(255 / LEVEL_STEPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]            r_state;
    logic [CH_W-1:0]       r_ch;
    logic                  r_func;
    logic [15:0]           r_idle;
    logic [MODES_W-1:0]    r_modes;
    logic [DIV_W-1:0]      r_bdiv, r_ddiv;
    logic [THRESH_W-1:0]   r_thresh;
    logic                  r_ovalid;
    t_out                  r_out;

    logic [1:0]            r_phase [CHANNELS];
    logic [STEP_W-1:0]     r_step  [CHANNELS];
    logic [HOLD_W-1:0]     r_hold  [CHANNELS];
    logic [LEVEL_W-1:0]    r_level [CHANNELS];
    logic [DUTY_W-1:0]     r_pduty [CHANNELS];
    logic [DUTY_W-1:0]     r_duty  [CHANNELS];
    logic                  r_en    [CHANNELS];

    t_div_req              div_req;
    logic                  div_busy, div_done;
    logic [DIVIDEND_W-1:0] quot;

    logic [1:0]            mode, cph, n_phase;
    logic [MODES_W-1:0]    modes_sh;
    logic [DIV_W-1:0]      b_eff, d_eff;
    logic [STEP_W-1:0]     cnt, lim_b, lim_d, n_step;
    logic [STEP_W:0]       inc;
    logic [HOLD_W-1:0]     n_hold;
    logic [LEVEL_W-1:0]    clev, n_level, lev_up;
    logic [DUTY_W-1:0]     cpd, n_pduty, n_duty, pd_dec;
    logic                  n_en, breathe_on, push_on, need_div;
    logic [DUTY_W-1:0]     dv [OUT_CH];
    logic [OUT_CH-1:0]     mask;

    lbf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        modes_sh   = r_modes >> {r_ch, 1'b0};
        mode       = modes_sh[1:0];
        b_eff      = (r_bdiv == '0) ? DIV_W'(1) : r_bdiv;
        d_eff      = (r_ddiv == '0) ? DIV_W'(1) : r_ddiv;
        lim_b      = {b_eff, 8'b0} - STEP_W'(b_eff);
        lim_d      = {d_eff, 8'b0} - STEP_W'(d_eff);
        breathe_on = (mode == MODE_BREATH) || ((mode == MODE_IDLE) && (r_idle > r_thresh));
        push_on    = (mode == MODE_PUSH);
        cph        = r_phase[r_ch];
        cnt        = r_step[r_ch];
        clev       = r_level[r_ch];
        cpd        = r_pduty[r_ch];
        inc        = {1'b0, cnt} + 1'b1;
        pd_dec     = cpd - 1'b1;
        lev_up     = clev + 1'b1;

        need_div = 1'b0;
        div_req  = '0;
        if (!r_func) begin
            if (breathe_on && (cph == PH_UP || cph == PH_DOWN)) begin
                need_div         = 1'b1;
                div_req.dividend = DIVIDEND_W'(cnt);
                div_req.divisor  = DIVISOR_W'((cph == PH_UP) ? b_eff : d_eff);
            end else if (push_on && r_hold[r_ch] == '0 && cpd != '0
                         && inc >= (STEP_W+1)'(d_eff)) begin
                need_div         = 1'b1;
                div_req.dividend = DIVIDEND_W'(FULL - pd_dec);
                div_req.divisor  = LOSS_DIV;
            end
        end else if (clev < LSTEPS) begin
            need_div         = 1'b1;
            div_req.dividend = {lev_up, 8'b0} - DIVIDEND_W'(lev_up);
            div_req.divisor  = DIVISOR_W'(LSTEPS);
        end
        div_req.start = (r_state == S_LOAD) && need_div;

        n_phase = cph;
        n_step  = cnt;
        n_hold  = r_hold[r_ch];
        n_level = clev;
        n_pduty = cpd;
        n_duty  = r_duty[r_ch];
        n_en    = r_en[r_ch];
        if (!r_func) begin
            if (breathe_on) begin
                unique case (cph)
                    PH_UP: begin
                        n_duty = (quot > DIVIDEND_W'(FULL)) ? FULL : quot[DUTY_W-1:0];
                        if (cnt >= lim_b) n_phase = PH_HOLD_H;
                        n_step = cnt + 1'b1;
                    end
                    PH_HOLD_H: begin
                        if (cnt >= lim_d) begin
                            n_phase = PH_DOWN;
                            n_step  = STEP_W'(1);
                        end else begin
                            n_step = cnt + 1'b1;
                        end
                    end
                    PH_DOWN: begin
                        n_duty = (quot > DIVIDEND_W'(FULL)) ? '0 : FULL - quot[DUTY_W-1:0];
                        if (cnt >= lim_d) n_phase = PH_HOLD_L;
                        n_step = cnt + 1'b1;
                    end
                    default: begin
                        if (cnt >= lim_b) begin
                            n_phase = PH_UP;
                            n_step  = STEP_W'(1);
                        end else begin
                            n_step = cnt + 1'b1;
                        end
                    end
                endcase
                n_en = 1'b1;
            end else if (push_on) begin
                if (r_hold[r_ch] != '0) begin
                    n_hold = r_hold[r_ch] - 1'b1;
                end else if (cpd != '0) begin
                    if (inc >= (STEP_W+1)'(d_eff)) begin
                        n_step  = '0;
                        n_pduty = pd_dec;
                        n_level = (quot >= DIVIDEND_W'(LSTEPS)) ? '0
                                  : LSTEPS - quot[LEVEL_W-1:0];
                    end else begin
                        n_step = inc[STEP_W-1:0];
                    end
                end else begin
                    n_level = '0;
                    n_step  = '0;
                end
                n_duty = n_pduty;
                n_en   = 1'b1;
            end else begin
                n_duty  = '0;
                n_en    = 1'b0;
                n_step  = '0;
                n_phase = PH_UP;
            end
        end else if (clev < LSTEPS) begin
            n_hold  = HOLD_TIME;
            n_level = lev_up;
            n_pduty = quot[DUTY_W-1:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < OUT_CH; g++) begin : g_out
            if (g < CHANNELS) begin : g_on
                assign dv[g]   = r_duty[g];
                assign mask[g] = r_en[g];
            end else begin : g_off
                assign dv[g]   = '0;
                assign mask[g] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes  <= 12'd1365;
            r_bdiv   <= 4'd3;
            r_ddiv   <= 4'd5;
            r_thresh <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODES:    r_modes  <= i_cfg_data[MODES_W-1:0];
                REG_BRIGHTEN: r_bdiv   <= i_cfg_data[DIV_W-1:0];
                REG_DARKEN:   r_ddiv   <= i_cfg_data[DIV_W-1:0];
                REG_THRESH:   r_thresh <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_phase[c] <= PH_UP;
                r_step[c]  <= '0;
                r_hold[c]  <= '0;
                r_level[c] <= '0;
                r_pduty[c] <= '0;
                r_duty[c]  <= '0;
                r_en[c]    <= 1'b0;
            end
        end else begin
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= i_data.func;
                        r_idle  <= i_data.idle_ms;
                        r_ch    <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: r_state <= need_div ? S_DIV : S_WRITE;
                S_DIV: if (div_done) r_state <= S_WRITE;
                S_WRITE: begin
                    r_phase[r_ch] <= n_phase;
                    r_step[r_ch]  <= n_step;
                    r_hold[r_ch]  <= n_hold;
                    r_level[r_ch] <= n_level;
                    r_pduty[r_ch] <= n_pduty;
                    r_duty[r_ch]  <= n_duty;
                    r_en[r_ch]    <= n_en;
                    if (r_ch == CH_W'(CHANNELS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out    <= '{dv[0], dv[1], dv[2], dv[3], dv[4], dv[5], mask};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !div_done) |-> div_busy)
        else $error("divider idle while sequencer waits");
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_LOAD && r_ch == '0))
        else $error("accepted transfer did not start channel sweep");
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch <= CH_W'(CHANNELS - 1))
        else $error("channel index out of range");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule
`default_nettype wire

### verif/led_breathing_and_level_fader_tb.sv
// testbench for the led breathing and level fader: random ticks and key presses,
// duty and enable predicted per channel and checked in order
// depends on lbf_pkg and led_breathing_and_level_fader
`timescale 1ns / 100ps
module led_breathing_and_level_fader_tb;
    import lbf_pkg::*;

    class fader_scoreboard;
        logic [11:0] modes;
        logic [3:0]  bdiv;
        logic [3:0]  ddiv;
        logic [15:0] thresh;
        logic [1:0]  phase [6];
        logic [11:0] stepc [6];
        logic [8:0]  holdc [6];
        logic [4:0]  level [6];
        logic [7:0]  pduty [6];
        logic [7:0]  duty [6];
        logic        en [6];
        t_out        pending [$];
        int          errors;

        function void clear();
            modes = 12'd1365;
            bdiv = 4'd3;
            ddiv = 4'd5;
            thresh = 16'd1000;
            for (int c = 0; c < 6; c++) begin
                phase[c] = PH_UP;
                stepc[c] = 0;
                holdc[c] = 0;
                level[c] = 0;
                pduty[c] = 0;
                duty[c] = 0;
                en[c] = 0;
            end
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_MODES:    modes = val[11:0];
                REG_BRIGHTEN: bdiv = val[3:0];
                REG_DARKEN:   ddiv = val[3:0];
                default:      thresh = val;
            endcase
        endfunction

        function void note_input(t_in d);
            int unsigned b, dv, cnt, q, loss;
            logic [1:0] m;
            t_out r;
            b = (bdiv == 0) ? 1 : bdiv;
            dv = (ddiv == 0) ? 1 : ddiv;
            if (d.func == 1'b0) begin
                for (int c = 0; c < 6; c++) begin
                    m = modes[2*c +: 2];
                    if (m == MODE_BREATH || (m == MODE_IDLE && d.idle_ms > thresh)) begin
                        cnt = stepc[c];
                        case (phase[c])
                            PH_UP: begin
                                q = cnt / b;
                                duty[c] = (q > 255) ? 8'd255 : q[7:0];
                                if (cnt >= 255 * b) phase[c] = PH_HOLD_H;
                            end
                            PH_HOLD_H: begin
                                if (cnt >= 255 * dv) begin
                                    cnt = 0;
                                    phase[c] = PH_DOWN;
                                end
                            end
                            PH_DOWN: begin
                                q = cnt / dv;
                                duty[c] = (q > 255) ? 8'd0 : 8'(255 - q);
                                if (cnt >= 255 * dv) phase[c] = PH_HOLD_L;
                            end
                            default: begin
                                if (cnt >= 255 * b) begin
                                    cnt = 0;
                                    phase[c] = PH_UP;
                                end
                            end
                        endcase
                        en[c] = 1;
                        stepc[c] = 12'(cnt + 1);
                    end else if (m == MODE_PUSH) begin
                        if (holdc[c] > 0) begin
                            holdc[c]--;
                        end else if (pduty[c] > 0) begin
                            cnt = stepc[c] + 1;
                            if (cnt >= dv) begin
                                cnt = 0;
                                pduty[c]--;
                                loss = (255 - pduty[c]) / 12;
                                level[c] = (loss >= 20) ? 5'd0 : 5'(20 - loss);
                            end
                            stepc[c] = 12'(cnt);
                        end else begin
                            level[c] = 0;
                            stepc[c] = 0;
                        end
                        duty[c] = pduty[c];
                        en[c] = 1;
                    end else begin
                        duty[c] = 0;
                        en[c] = 0;
                        stepc[c] = 0;
                        phase[c] = PH_UP;
                    end
                end
            end else begin
                for (int c = 0; c < 6; c++) begin
                    if (level[c] < 20) begin
                        holdc[c] = HOLD_TIME;
                        level[c]++;
                        pduty[c] = 8'((255 * int'(level[c])) / 20);
                    end
                end
            end
            r.duty_ch0 = duty[0];
            r.duty_ch1 = duty[1];
            r.duty_ch2 = duty[2];
            r.duty_ch3 = duty[3];
            r.duty_ch4 = duty[4];
            r.duty_ch5 = duty[5];
            for (int c = 0; c < 6; c++) r.pwm_enable_mask[c] = en[c];
            pending.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.duty_ch0 !== want.duty_ch0 || got.duty_ch1 !== want.duty_ch1 ||
                got.duty_ch2 !== want.duty_ch2 || got.duty_ch3 !== want.duty_ch3 ||
                got.duty_ch4 !== want.duty_ch4 || got.duty_ch5 !== want.duty_ch5 ||
                got.pwm_enable_mask !== want.pwm_enable_mask) begin
                $display("%0t: mismatch expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_data;
    logic        out_valid;
    logic        out_stall;
    t_out        out_data;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    fader_scoreboard sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off;
    int          cycles;
    bit          done;

    led_breathing_and_level_fader DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // receiver side: random stall, long hold-off when asked
    always @(negedge clk) begin
        if (hold_off > 0) begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("led_breathing_and_level_fader_tb: FAIL");
            $finish;
        end
    end

    // valid stays high into the next item unless the sender idles
    task automatic send_item(logic f, logic [15:0] idle);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{func: f, idle_ms: idle};
        do @(posedge clk); while (in_stall);
        sb.note_input('{func: f, idle_ms: idle});
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_config();
        set_reg(REG_MODES, 16'($urandom_range(4095)));
        set_reg(REG_BRIGHTEN, 16'($urandom_range(15)));
        set_reg(REG_DARKEN, 16'($urandom_range(15)));
        set_reg(REG_THRESH, 16'($urandom_range(3) == 0 ? $urandom_range(65535)
                                                      : $urandom_range(300)));
    endtask

    task automatic random_items(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) send_item(1'b1, 16'($urandom));
            else send_item(1'b0, ($urandom_range(3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(400)));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_we = 0;
        cfg_idx = REG_MODES;
        cfg_data = '0;
        hold_off = 0;
        cycles = 0;
        send_idle_pct = 32;
        recv_idle_pct = 71;
        repeat (2) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: all modes mixed, divisor extremes, idle edge
        set_reg(REG_MODES, 16'({MODE_PUSH, MODE_IDLE, MODE_BREATH, MODE_OFF, MODE_PUSH,
                                MODE_IDLE}));
        set_reg(REG_BRIGHTEN, 16'd0);
        set_reg(REG_DARKEN, 16'd15);
        set_reg(REG_THRESH, 16'd100);
        send_item(1'b0, 16'd100);
        send_item(1'b0, 16'd101);
        send_item(1'b0, 16'hFFFF);
        send_item(1'b0, 16'd0);
        for (int k = 0; k < 12; k++) send_item(1'b1, 16'hFFFF);
        for (int k = 0; k < 8; k++) send_item(1'b0, 16'($urandom));
        drain();
        set_reg(REG_MODES, 16'hFFFF);
        set_reg(REG_BRIGHTEN, 16'd15);
        set_reg(REG_DARKEN, 16'd0);
        set_reg(REG_THRESH, 16'hFFFF);
        send_item(1'b0, 16'hFFFF);
        drain();

        // pushed level raised to full, then ticks while it is held, fast darken divisor
        set_reg(REG_MODES, 16'hFFF);
        set_reg(REG_DARKEN, 16'd1);
        for (int k = 0; k < 21; k++) send_item(1'b1, 16'd0);
        send_idle_pct = 32;
        recv_idle_pct = 71;
        random_items(80);
        drain();

        // breathing ramp-up with small divisors
        set_reg(REG_MODES, 16'h555);
        set_reg(REG_BRIGHTEN, 16'd1);
        set_reg(REG_DARKEN, 16'd1);
        random_items(150);
        drain();

        send_idle_pct = 71;
        recv_idle_pct = 32;
        for (int p = 0; p < 4; p++) begin
            random_config();
            random_items(100);
            drain();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        hold_off = 300;
        random_items(120);
        drain();
        for (int p = 0; p < 3; p++) begin
            random_config();
            random_items(110);
            drain();
        end

        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("led_breathing_and_level_fader_tb: PASS");
        else
            $display("led_breathing_and_level_fader_tb: FAIL");
        $finish;
    end
endmodule

### sim.f
src/lbf_pkg.sv
src/lbf_divider.sv
src/led_breathing_and_level_fader.sv
verif/led_breathing_and_level_fader_tb.sv
